@@ sv/trl_pkg.sv @@
package trl_pkg;

    // field widths
    localparam int RATE_W  = 19;
    localparam int ACCEL_W = 20;
    localparam int ERR_W   = 16;
    localparam int CUR_W   = 20;
    localparam int DT_W    = 16;
    localparam int CMD_W   = 20;
    localparam int WIN_W   = 22;

    // register file
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_RATE  = 1'b0;
    localparam logic REG_ACCEL = 1'b1;
    localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(12288);
    localparam logic [ACCEL_W-1:0] ACCEL_RESET = ACCEL_W'(40960);

    // square root pipeline
    localparam int SQ_IN_W      = 36;
    localparam int SQ_OUT_W     = SQ_IN_W / 2;
    localparam int SQ_REM_W     = SQ_OUT_W + 2;
    localparam int SQ_PER_STAGE = 2;
    localparam int SQ_STAGES    = SQ_OUT_W / SQ_PER_STAGE;

    localparam logic signed [CMD_W-1:0] CMD_MAX = {1'b0, {(CMD_W-1){1'b1}}};
    localparam logic signed [CMD_W-1:0] CMD_MIN = {1'b1, {(CMD_W-1){1'b0}}};

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_OUT_W-1:0] root;
        logic [SQ_IN_W-1:0]  rad;
    } t_sq;

    typedef struct packed {
        logic [WIN_W-1:0] cmd;
        logic             acc;
        logic             dir;
    } t_side;

    // one result bit of the digit-by-digit square root
    function automatic t_sq sq_step(t_sq s);
        logic [SQ_REM_W+1:0] cur;
        logic [SQ_REM_W+1:0] trial;
        t_sq                 r;
        cur   = {s.rem, s.rad[SQ_IN_W-1 -: 2]};
        trial = (SQ_REM_W+2)'({s.root, 2'b01});
        r.rad = {s.rad[SQ_IN_W-3:0], 2'b00};
        if (cur >= trial) begin
            r.rem  = SQ_REM_W'(cur - trial);
            r.root = {s.root[SQ_OUT_W-2:0], 1'b1};
        end else begin
            r.rem  = SQ_REM_W'(cur);
            r.root = {s.root[SQ_OUT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ sv/trl_front.sv @@
module trl_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [trl_pkg::ERR_W-1:0]  i_heading_error,
    input  logic signed [trl_pkg::CUR_W-1:0]  i_current_rate,
    input  logic [trl_pkg::DT_W-1:0]          i_time_step,
    input  logic [trl_pkg::RATE_W-1:0]        i_max_rate,
    input  logic [trl_pkg::ACCEL_W-1:0]       i_max_accel,
    output logic                              o_valid,
    output logic [trl_pkg::SQ_IN_W-1:0]       o_rad,
    output trl_pkg::t_side                    o_side
);

    localparam int PROD_W = trl_pkg::ACCEL_W + trl_pkg::DT_W;

    logic [trl_pkg::ERR_W-1:0]         w_abs_err;
    logic [PROD_W-1:0]                 w_prod_dt;
    logic [PROD_W-1:0]                 w_prod_stop;
    logic                              w_dir;

    logic                              r1_valid;
    logic [trl_pkg::ACCEL_W-1:0]       r1_delta;
    logic signed [trl_pkg::CUR_W-1:0]  r1_rate;
    logic                              r1_dir;
    logic [trl_pkg::SQ_IN_W-1:0]       r1_rad;

    logic signed [trl_pkg::WIN_W-1:0]  w_req;
    logic signed [trl_pkg::WIN_W-1:0]  w_rate;
    logic signed [trl_pkg::WIN_W-1:0]  w_delta;
    logic signed [trl_pkg::WIN_W-1:0]  w_lo;
    logic signed [trl_pkg::WIN_W-1:0]  w_hi;
    trl_pkg::t_side                    n_side;

    logic                              r2_valid;
    logic [trl_pkg::SQ_IN_W-1:0]       r2_rad;
    trl_pkg::t_side                    r2_side;

    // stage 1: the two products
    assign w_dir       = !i_heading_error[trl_pkg::ERR_W-1] && (i_heading_error != '0);
    assign w_abs_err   = i_heading_error[trl_pkg::ERR_W-1]
                       ? trl_pkg::ERR_W'(-i_heading_error) : trl_pkg::ERR_W'(i_heading_error);
    assign w_prod_dt   = PROD_W'(i_max_accel) * PROD_W'(i_time_step);
    assign w_prod_stop = PROD_W'(i_max_accel) * PROD_W'(w_abs_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_delta <= w_prod_dt[PROD_W-1 -: trl_pkg::ACCEL_W];
            r1_rate  <= i_current_rate;
            r1_dir   <= w_dir;
            // radicand is 2*accel*|err|; top product bit is always zero
            r1_rad   <= {w_prod_stop[trl_pkg::SQ_IN_W-2:0], 1'b0};
            r2_rad   <= r1_rad;
            r2_side  <= n_side;
        end
    end

    // stage 2: acceleration window clamp
    assign w_req   = r1_dir ? $signed(trl_pkg::WIN_W'(i_max_rate))
                            : -$signed(trl_pkg::WIN_W'(i_max_rate));
    assign w_rate  = trl_pkg::WIN_W'(r1_rate);
    assign w_delta = $signed(trl_pkg::WIN_W'(r1_delta));
    assign w_lo    = w_rate - w_delta;
    assign w_hi    = w_rate + w_delta;

    always_comb begin
        n_side.dir = r1_dir;
        if (w_req < w_lo) begin
            n_side.cmd = w_lo;
            n_side.acc = 1'b1;
        end else if (w_req > w_hi) begin
            n_side.cmd = w_hi;
            n_side.acc = 1'b1;
        end else begin
            n_side.cmd = w_req;
            n_side.acc = 1'b0;
        end
    end

    assign o_valid = r2_valid;
    assign o_rad   = r2_rad;
    assign o_side  = r2_side;

endmodule

@@ sv/trl_sqrt.sv @@
module trl_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [trl_pkg::SQ_IN_W-1:0]    i_rad,
    input  trl_pkg::t_side                 i_side,
    output logic                           o_valid,
    output logic [trl_pkg::SQ_OUT_W-1:0]   o_root,
    output trl_pkg::t_side                 o_side
);

    localparam int S = trl_pkg::SQ_STAGES;

    logic [S-1:0]    r_valid;
    trl_pkg::t_sq    r_sq   [S];
    trl_pkg::t_side  r_side [S];
    trl_pkg::t_sq    n_sq   [S];

    // each stage resolves SQ_PER_STAGE root bits, starting from the previous stage's registers (stage 0 from the input)
    always_comb begin
        trl_pkg::t_sq w_cur;
        for (int s = 0; s < S; s++) begin
            if (s == 0) begin
                w_cur.rem  = '0;
                w_cur.root = '0;
                w_cur.rad  = i_rad;
            end else begin
                w_cur = r_sq[s-1];
            end
            for (int k = 0; k < trl_pkg::SQ_PER_STAGE; k++) begin
                w_cur = trl_pkg::sq_step(w_cur);
            end
            n_sq[s] = w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[S-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < S; s++) begin
                r_sq[s]   <= n_sq[s];
                r_side[s] <= (s == 0) ? i_side : r_side[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign o_valid = r_valid[S-1];
    assign o_root  = r_sq[S-1].root;
    assign o_side  = r_side[S-1];

endmodule

@@ sv/trl_final.sv @@
module trl_final (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [trl_pkg::SQ_OUT_W-1:0]     i_root,
    input  trl_pkg::t_side                   i_side,
    output logic                             o_valid,
    output logic signed [trl_pkg::CMD_W-1:0] o_commanded_rate,
    output logic                             o_accel_limited,
    output logic                             o_stop_limited
);

    localparam int W = trl_pkg::WIN_W;

    logic signed [W-1:0]             w_cmd;
    logic [W-1:0]                    w_mag;
    logic [W-1:0]                    w_bound;
    logic signed [W-1:0]             w_lim;
    logic                            w_stop;
    logic signed [trl_pkg::CMD_W-1:0] w_sat;

    logic                            r_valid;
    logic signed [trl_pkg::CMD_W-1:0] r_cmd;
    logic                            r_acc;
    logic                            r_stop;

    assign w_cmd   = $signed(i_side.cmd);
    assign w_mag   = w_cmd[W-1] ? W'(-w_cmd) : W'(w_cmd);
    assign w_bound = W'(i_root);
    assign w_stop  = w_mag > w_bound;

    // stopping bound keeps the chosen direction
    always_comb begin
        if (w_stop) begin
            w_lim = i_side.dir ? $signed(w_bound) : -$signed(w_bound);
        end else begin
            w_lim = w_cmd;
        end
    end

    // saturate when the top bits do not all match the sign
    always_comb begin
        if (w_lim[W-1:trl_pkg::CMD_W-1] == '0 || w_lim[W-1:trl_pkg::CMD_W-1] == '1) begin
            w_sat = w_lim[trl_pkg::CMD_W-1:0];
        end else if (w_lim[W-1]) begin
            w_sat = trl_pkg::CMD_MIN;
        end else begin
            w_sat = trl_pkg::CMD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd  <= w_sat;
            r_acc  <= i_side.acc;
            r_stop <= w_stop;
        end
    end

    assign o_valid          = r_valid;
    assign o_commanded_rate = r_cmd;
    assign o_accel_limited  = r_acc;
    assign o_stop_limited   = r_stop;

endmodule

@@ sv/turn_rate_limiter_top.sv @@
// channel   | handshake                 | payload
// ----------+---------------------------+--------------------------------------------
// input     | i_in_valid / o_in_ready   | i_heading_error, i_current_rate, i_time_step
// output    | o_out_valid / i_out_ready | o_commanded_rate, o_accel_limited,
//           |                           | o_stop_limited
// config    | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// one request can enter every cycle unless the output stalls; the path runs through two front
// stages, nine square root stages at two root bits each and one output register
// the square root pipeline depth sets the latency, the rate is one per cycle when not stalled
// synchronous active-low reset clears the valid bits and loads register defaults
// the whole pipeline holds when the output register is full and not taken
module turn_rate_limiter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [trl_pkg::ERR_W-1:0]  i_heading_error,
    input  logic signed [trl_pkg::CUR_W-1:0]  i_current_rate,
    input  logic [trl_pkg::DT_W-1:0]          i_time_step,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [trl_pkg::CMD_W-1:0]  o_commanded_rate,
    output logic                              o_accel_limited,
    output logic                              o_stop_limited,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [trl_pkg::ADDR_W-1:0]        paddr,
    input  logic [trl_pkg::DATA_W-1:0]        pwdata,
    output logic [trl_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    logic [trl_pkg::RATE_W-1:0]   r_max_rate;
    logic [trl_pkg::ACCEL_W-1:0]  r_max_accel;
    logic                         w_wr;
    logic                         w_reg_sel;
    logic                         w_en;

    logic                         w_front_valid;
    logic [trl_pkg::SQ_IN_W-1:0]  w_front_rad;
    trl_pkg::t_side               w_front_side;

    logic                         w_sq_valid;
    logic [trl_pkg::SQ_OUT_W-1:0] w_sq_root;
    trl_pkg::t_side               w_sq_side;

    // register file: word address picks the register
    assign pready    = 1'b1;
    assign w_reg_sel = paddr[2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rate  <= trl_pkg::RATE_RESET;
            r_max_accel <= trl_pkg::ACCEL_RESET;
        end else if (w_wr) begin
            unique case (w_reg_sel)
                trl_pkg::REG_RATE:  r_max_rate  <= pwdata[trl_pkg::RATE_W-1:0];
                trl_pkg::REG_ACCEL: r_max_accel <= pwdata[trl_pkg::ACCEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            trl_pkg::REG_RATE:  prdata = trl_pkg::DATA_W'(r_max_rate);
            trl_pkg::REG_ACCEL: prdata = trl_pkg::DATA_W'(r_max_accel);
            default:            prdata = '0;
        endcase
    end

    // pipeline advances unless a finished result is waiting to be taken
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // products, direction and acceleration window
    trl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (i_in_valid),
        .i_heading_error (i_heading_error),
        .i_current_rate  (i_current_rate),
        .i_time_step     (i_time_step),
        .i_max_rate      (r_max_rate),
        .i_max_accel     (r_max_accel),
        .o_valid         (w_front_valid),
        .o_rad           (w_front_rad),
        .o_side          (w_front_side)
    );

    // stopping-distance bound, window result rides alongside
    trl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_valid),
        .i_rad   (w_front_rad),
        .i_side  (w_front_side),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // magnitude limit, saturation and output register
    trl_final u_final (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_valid          (w_sq_valid),
        .i_root           (w_sq_root),
        .i_side           (w_sq_side),
        .o_valid          (o_out_valid),
        .o_commanded_rate (o_commanded_rate),
        .o_accel_limited  (o_accel_limited),
        .o_stop_limited   (o_stop_limited)
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PER_SET = 165;
    localparam int LONG_HOLD     = 120;
    localparam int DRAIN_CYCLES  = 20;

    // register byte addresses, one 32-bit word per register
    localparam logic [trl_pkg::ADDR_W-1:0] ADDR_TURN_RATE  =
        trl_pkg::ADDR_W'(4 * int'(trl_pkg::REG_RATE));
    localparam logic [trl_pkg::ADDR_W-1:0] ADDR_TURN_ACCEL =
        trl_pkg::ADDR_W'(4 * int'(trl_pkg::REG_ACCEL));

    // one steering request as presented on the input channel
    typedef struct packed {
        logic signed [trl_pkg::ERR_W-1:0] err;
        logic signed [trl_pkg::CUR_W-1:0] rate;
        logic [trl_pkg::DT_W-1:0]         dt;
    } t_heading_req;

    // one limited turn command as seen on the output channel
    typedef struct packed {
        logic signed [trl_pkg::CMD_W-1:0] rate;
        logic                             accel;
        logic                             stop;
    } t_turn_cmd;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                             i_in_valid      = 1'b0;
    logic                             o_in_ready;
    logic signed [trl_pkg::ERR_W-1:0] i_heading_error = '0;
    logic signed [trl_pkg::CUR_W-1:0] i_current_rate  = '0;
    logic [trl_pkg::DT_W-1:0]         i_time_step     = '0;

    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic signed [trl_pkg::CMD_W-1:0] o_commanded_rate;
    logic                             o_accel_limited;
    logic                             o_stop_limited;

    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [trl_pkg::ADDR_W-1:0] paddr   = '0;
    logic [trl_pkg::DATA_W-1:0] pwdata  = '0;
    logic [trl_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    // mirror of the limit registers, only changed while nothing is in flight
    logic [trl_pkg::RATE_W-1:0]  turn_rate_lim  = trl_pkg::RATE_RESET;
    logic [trl_pkg::ACCEL_W-1:0] turn_accel_lim = trl_pkg::ACCEL_RESET;

    t_heading_req pending_reqs[$];
    t_turn_cmd    expected_cmds[$];

    bit idle_on = 1'b1;
    int error_count   = 0;
    int requests_sent = 0;
    int cmds_checked  = 0;
    int accel_hits    = 0;
    int stop_hits     = 0;
    int limit_sets    = 1;
    int cycle_count   = 0;
    int in_gap        = 0;
    int out_gap       = 0;
    int out_hold      = 0;

    turn_rate_limiter_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_heading_error  (i_heading_error),
        .i_current_rate   (i_current_rate),
        .i_time_step      (i_time_step),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_commanded_rate (o_commanded_rate),
        .o_accel_limited  (o_accel_limited),
        .o_stop_limited   (o_stop_limited),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #2 i_clk = ~i_clk;

    // floor square root, one result bit per pass from the top down
    function automatic longint stop_bound_root(longint x);
        longint root;
        longint trial;
        root = 0;
        for (int b = trl_pkg::SQ_OUT_W; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // expected command for one request under the present limits
    function automatic t_turn_cmd predict_turn_cmd(t_heading_req req);
        longint    err;
        longint    cur;
        longint    dir;
        longint    cmd;
        longint    delta;
        longint    lo;
        longint    hi;
        longint    abs_err;
        longint    bound;
        longint    mag;
        t_turn_cmd res;
        err   = longint'($signed(req.err));
        cur   = longint'($signed(req.rate));
        dir   = (err > 0) ? 1 : -1;
        cmd   = dir * longint'(turn_rate_lim);
        // accel * dt keeps the accel fraction bits, dt is a pure fraction
        delta = (longint'(turn_accel_lim) * longint'(req.dt)) >> 16;
        lo    = cur - delta;
        hi    = cur + delta;
        res.accel = 1'b0;
        res.stop  = 1'b0;
        if (cmd < lo) begin
            cmd       = lo;
            res.accel = 1'b1;
        end else if (cmd > hi) begin
            cmd       = hi;
            res.accel = 1'b1;
        end
        // stopping distance: |w| <= sqrt(2 * a * |err|)
        abs_err = (err < 0) ? -err : err;
        bound   = stop_bound_root(2 * longint'(turn_accel_lim) * abs_err);
        mag     = (cmd < 0) ? -cmd : cmd;
        if (mag > bound) begin
            cmd      = dir * bound;
            res.stop = 1'b1;
        end
        if (cmd > longint'(trl_pkg::CMD_MAX))
            cmd = longint'(trl_pkg::CMD_MAX);
        if (cmd < longint'(trl_pkg::CMD_MIN))
            cmd = longint'(trl_pkg::CMD_MIN);
        res.rate = trl_pkg::CMD_W'(cmd);
        return res;
    endfunction

    // request driver: valid holds with a stable payload until taken
    always @(posedge i_clk) begin : req_driver
        t_heading_req nxt;
        bit           busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                nxt.err  = i_heading_error;
                nxt.rate = i_current_rate;
                nxt.dt   = i_time_step;
                expected_cmds.push_back(predict_turn_cmd(nxt));
                requests_sent++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (in_gap != 0) begin
                    in_gap     <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (idle_on && pending_reqs.size() != 0 &&
                             $urandom_range(0, 7) == 0) begin
                    // idle burst starts here, in_gap holds the rest of it
                    in_gap     <= $urandom_range(0, 10);
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    nxt = pending_reqs.pop_front();
                    i_in_valid      <= 1'b1;
                    i_heading_error <= nxt.err;
                    i_current_rate  <= nxt.rate;
                    i_time_step     <= nxt.dt;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // command monitor: checks every taken command and paces out_ready
    always @(posedge i_clk) begin : cmd_monitor
        t_turn_cmd exp_cmd;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: command with nothing expected: rate %0d acc %0b stop %0b",
                             $time, o_commanded_rate, o_accel_limited, o_stop_limited);
                    error_count++;
                end else begin
                    exp_cmd = expected_cmds.pop_front();
                    if (o_commanded_rate !== exp_cmd.rate) begin
                        $display("%0t: commanded_rate expected %0d actual %0d",
                                 $time, exp_cmd.rate, o_commanded_rate);
                        error_count++;
                    end
                    if (o_accel_limited !== exp_cmd.accel) begin
                        $display("%0t: accel_limited expected %0b actual %0b",
                                 $time, exp_cmd.accel, o_accel_limited);
                        error_count++;
                    end
                    if (o_stop_limited !== exp_cmd.stop) begin
                        $display("%0t: stop_limited expected %0b actual %0b",
                                 $time, exp_cmd.stop, o_stop_limited);
                        error_count++;
                    end
                    accel_hits += exp_cmd.accel;
                    stop_hits  += exp_cmd.stop;
                end
                cmds_checked++;
                // long back-pressure so the pipeline fills and input stalls
                if (cmds_checked == 250 || cmds_checked == 650)
                    out_hold = LONG_HOLD;
            end
            if (out_hold != 0) begin
                out_hold--;
                i_out_ready <= 1'b0;
            end else if (out_gap != 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(0, 10);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d commands outstanding", $time,
                     expected_cmds.size());
            $display("turn_rate_limiter_top regression: fail");
            $finish;
        end
    end

    // setup phase, then access phase, data sampled at the access edge
    task automatic apb_access(input logic [trl_pkg::ADDR_W-1:0] addr, input bit wr,
                              input logic [trl_pkg::DATA_W-1:0] wdata,
                              output logic [trl_pkg::DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write both limits with junk in the unused upper bits, then read back
    task automatic program_limits(input logic [trl_pkg::RATE_W-1:0] peak,
                                  input logic [trl_pkg::ACCEL_W-1:0] accel);
        logic [trl_pkg::DATA_W-1:0] junk;
        logic [trl_pkg::DATA_W-1:0] rd;
        junk = $urandom;
        apb_access(ADDR_TURN_RATE, 1'b1,
                   {junk[trl_pkg::DATA_W-1:trl_pkg::RATE_W], peak}, rd);
        turn_rate_lim = peak;
        junk = $urandom;
        apb_access(ADDR_TURN_ACCEL, 1'b1,
                   {junk[trl_pkg::DATA_W-1:trl_pkg::ACCEL_W], accel}, rd);
        turn_accel_lim = accel;
        apb_access(ADDR_TURN_RATE, 1'b0, '0, rd);
        if (rd !== trl_pkg::DATA_W'(peak)) begin
            $display("%0t: max_turn_rate readback expected %0h actual %0h",
                     $time, trl_pkg::DATA_W'(peak), rd);
            error_count++;
        end
        apb_access(ADDR_TURN_ACCEL, 1'b0, '0, rd);
        if (rd !== trl_pkg::DATA_W'(accel)) begin
            $display("%0t: max_turn_accel readback expected %0h actual %0h",
                     $time, trl_pkg::DATA_W'(accel), rd);
            error_count++;
        end
        limit_sets++;
    endtask

    task automatic add_req(input int err, input int cur, input int dt);
        t_heading_req r;
        r.err  = trl_pkg::ERR_W'(err);
        r.rate = trl_pkg::CUR_W'(cur);
        r.dt   = trl_pkg::DT_W'(dt);
        pending_reqs.push_back(r);
    endtask

    // field extremes, zero error, a window pointing the wrong way, window overflow
    task automatic add_directed_reqs();
        add_req(0, 0, 0);
        add_req(0, 300000, 65535);
        add_req(0, -524288, 65535);
        add_req(32767, 0, 65535);
        add_req(-32768, 0, 65535);
        add_req(1, 0, 65535);
        add_req(-1, 0, 65535);
        add_req(32767, -524288, 10);
        add_req(-32768, 524287, 10);
        add_req(32767, 524287, 65535);
        add_req(-32768, -524288, 65535);
        add_req(4096, 12288, 0);
        add_req(-4096, -12288, 655);
        add_req(100, 5000, 3277);
        add_req(-20000, -524288, 0);
        add_req(32767, 524287, 0);
        add_req(1, -524288, 65535);
        add_req(32767, 0, 1);
        add_req(-32768, 1, 65535);
    endtask

    // mostly plausible steering requests, some raw random words
    task automatic add_random_reqs(input int count);
        int mode;
        int peak;
        int err;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 3);
            peak = int'(turn_rate_lim) + 64;
            if (mode == 0) begin
                add_req($urandom, $urandom, $urandom);
            end else begin
                if (mode == 1)
                    err = $urandom_range(0, 4) - 2;
                else
                    err = $urandom_range(0, 12000) - 6000;
                add_req(err, $urandom_range(0, 2 * peak) - peak,
                        $urandom_range(0, 3300));
            end
        end
    endtask

    // wait until every request is taken and every command checked
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_cmds.size() != 0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset limits first
        add_directed_reqs();
        add_random_reqs(RANDOM_PER_SET);
        wait_drained();

        // both limits at their top
        program_limits({trl_pkg::RATE_W{1'b1}}, {trl_pkg::ACCEL_W{1'b1}});
        @(negedge i_clk);
        add_directed_reqs();
        add_random_reqs(RANDOM_PER_SET);
        wait_drained();

        // both limits zero: every command collapses to zero
        program_limits('0, '0);
        @(negedge i_clk);
        add_random_reqs(RANDOM_PER_SET);
        wait_drained();

        // no peak rate, full acceleration, run without idling
        program_limits('0, {trl_pkg::ACCEL_W{1'b1}});
        @(negedge i_clk);
        idle_on = 1'b0;
        add_random_reqs(RANDOM_PER_SET);
        wait_drained();

        // full peak rate, no acceleration
        program_limits({trl_pkg::RATE_W{1'b1}}, '0);
        @(negedge i_clk);
        idle_on = 1'b1;
        add_random_reqs(RANDOM_PER_SET);
        wait_drained();

        // a random setting
        program_limits(trl_pkg::RATE_W'($urandom), trl_pkg::ACCEL_W'($urandom));
        @(negedge i_clk);
        add_random_reqs(RANDOM_PER_SET);
        wait_drained();

        // moderate random setting, both sides at full speed to the end
        program_limits(trl_pkg::RATE_W'($urandom_range(1000, 60000)),
                       trl_pkg::ACCEL_W'($urandom_range(1000, 200000)));
        @(negedge i_clk);
        idle_on = 1'b0;
        add_random_reqs(RANDOM_PER_SET);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d requests over %0d limit settings, %0d commands checked",
                 requests_sent, limit_sets, cmds_checked);
        $display("acceleration window acted %0d times, stopping bound %0d times",
                 accel_hits, stop_hits);
        if (error_count == 0 && expected_cmds.size() == 0)
            $display("turn_rate_limiter_top regression: pass");
        else
            $display("turn_rate_limiter_top regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/trl_pkg.sv
sv/trl_front.sv
sv/trl_sqrt.sv
sv/trl_final.sv
sv/turn_rate_limiter_top.sv
test/tb.sv
